// File: rtl/fcw_pkg.sv
// shared types and constants of the feistel cycle-walk permutation unit
package fcw_pkg;

	// offset and moduli of the permuted range
	localparam logic [31:0] MOD_A    = 32'h0000_ffff;
	localparam logic [31:0] MOD_B    = 32'h0001_0000;
	localparam logic [31:0] WALK_MIN = 32'hffff_0000;

	// murmur3 x86_32 constants
	localparam logic [31:0] MUR_C1 = 32'hcc9e_2d51;
	localparam logic [31:0] MUR_C2 = 32'h1b87_3593;
	localparam logic [31:0] MUR_F1 = 32'h85eb_ca6b;
	localparam logic [31:0] MUR_F2 = 32'hc2b2_ae35;
	localparam logic [31:0] MUR_LEN = 32'h0000_0002;

	localparam int unsigned NUM_ROUNDS = 4;
	localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);

	localparam logic [31:0] ROUND_SEED [NUM_ROUNDS] = '{
		32'hb76d_5eed, 32'hee28_1300, 32'h85bc_ae01, 32'h4b38_7af7
	};

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SPLIT,
		OP_K1,
		OP_K2,
		OP_H1,
		OP_H2,
		OP_ROUND,
		OP_PACK,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [ROUND_W-1:0]  round;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic walk;
		logic out_free;
	} status_t;

endpackage

// File: rtl/feistel_cycle_walk_permutation_unit.sv
// top level of the feistel cycle-walk permutation unit
//
// Input channel: value_in with in_valid / in_stall; an item is taken on a
// rising edge with in_valid high and in_stall low. Output channel: value_out
// with out_valid / out_stall, same rule.
// Items whose low 32 bits are below 0x10000 come out unchanged. Others run
// four feistel rounds (four multiplies on one shared 32x32 multiplier, then
// the modular add, in each round), plus split, pack and check, and run them
// all a second time when the cycle walk needs a second pass.
// One item is in work at a time; the next can be taken in the cycle after
// the result enters the output register.
// The output register holds a finished item while out_stall is high, and a
// new item may be taken meanwhile; a later result waits until it drains.
// Reset (arst_n low) returns the controller to idle and drops out_valid.
module feistel_cycle_walk_permutation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value_out
);
	import fcw_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	fcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and storage
	fcw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out)
	);

endmodule

// File: rtl/fcw_ctrl.sv
// controller state machine: sequences split, hash rounds, pack and cycle walk
module fcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  fcw_pkg::status_t status,
	output fcw_pkg::cmd_t    cmd
);
	import fcw_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_SPLIT = 10'b00_0000_0010,
		S_K1    = 10'b00_0000_0100,
		S_K2    = 10'b00_0000_1000,
		S_H1    = 10'b00_0001_0000,
		S_H2    = 10'b00_0010_0000,
		S_ROUND = 10'b00_0100_0000,
		S_PACK  = 10'b00_1000_0000,
		S_CHECK = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [ROUND_W-1:0] round_q, round_d;
	logic               pass_q, pass_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and command decode
	always_comb begin
		state_d   = state_q;
		round_d   = round_q;
		pass_d    = pass_q;
		cmd.op    = OP_NONE;
		cmd.round = round_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					pass_d  = 1'b0;
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				if (status.bypass) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_SPLIT;
					round_d = '0;
					state_d = S_K1;
				end
			end
			S_K1: begin
				cmd.op  = OP_K1;
				state_d = S_K2;
			end
			S_K2: begin
				cmd.op  = OP_K2;
				state_d = S_H1;
			end
			S_H1: begin
				cmd.op  = OP_H1;
				state_d = S_H2;
			end
			S_H2: begin
				cmd.op  = OP_H2;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.op = OP_ROUND;
				if (round_q == ROUND_W'(NUM_ROUNDS - 1)) begin
					state_d = S_PACK;
				end else begin
					round_d = round_q + 1'b1;
					state_d = S_K1;
				end
			end
			S_PACK: begin
				cmd.op  = OP_PACK;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				// one extra pass at most when the result lands in the top block
				if (status.walk && !pass_q) begin
					pass_d  = 1'b1;
					state_d = S_SPLIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			pass_q  <= pass_d;
		end
	end

endmodule

// File: rtl/fcw_datapath.sv
// datapath: value registers, shared 32x32 multiplier, modular adds, output register
module fcw_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  fcw_pkg::cmd_t    cmd,
	output fcw_pkg::status_t status,
	input  logic [63:0]      value_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [63:0]      value_out
);
	import fcw_pkg::*;

	logic [63:0] value_q;
	logic [31:0] m_q;
	logic [16:0] left_q;
	logic [16:0] right_q;
	logic [31:0] acc_q;
	logic [63:0] value_out_q;
	logic        out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] h_mix;
	logic [31:0] f_hash;

	logic [16:0] split_sum;
	logic [16:0] split_left;
	logic [16:0] split_right;

	logic [32:0] rnd_sum;
	logic [17:0] fold1;
	logic [16:0] fold2;
	logic [15:0] rnd_t;

	logic [31:0] pk_hi;
	logic [31:0] pk_lo;
	logic [31:0] packed_val;
	logic        bypass;

	assign bypass = (value_q[31:16] == 16'h0000);

	assign status.bypass   = bypass;
	assign status.walk     = (m_q >= WALK_MIN);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;

	// split m into m mod 0xffff and m div 0xffff, using 2^16 = 1 mod 0xffff
	always_comb begin
		split_sum = {1'b0, m_q[31:16]} + {1'b0, m_q[15:0]};
		if (split_sum == 17'h1_fffe) begin
			split_left  = 17'h0_0000;
			split_right = {1'b0, m_q[31:16]} + 17'd2;
		end else if (split_sum >= 17'h0_ffff) begin
			split_left  = split_sum - 17'h0_ffff;
			split_right = {1'b0, m_q[31:16]} + 17'd1;
		end else begin
			split_left  = split_sum;
			split_right = {1'b0, m_q[31:16]};
		end
	end

	// shared multiplier operand select
	always_comb begin
		h_mix = ROUND_SEED[cmd.round] ^ acc_q ^ MUR_LEN;
		h_mix = h_mix ^ (h_mix >> 16);
		case (cmd.op)
			OP_K1: begin
				mul_a = {16'h0000, right_q[15:0]};
				mul_b = MUR_C1;
			end
			OP_K2: begin
				mul_a = {acc_q[16:0], acc_q[31:17]};
				mul_b = MUR_C2;
			end
			OP_H1: begin
				mul_a = h_mix;
				mul_b = MUR_F1;
			end
			OP_H2: begin
				mul_a = acc_q ^ (acc_q >> 13);
				mul_b = MUR_F2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// round update: hash plus left, reduced mod 0xffff (even) or 0x10000 (odd)
	always_comb begin
		f_hash  = acc_q ^ (acc_q >> 16);
		rnd_sum = {1'b0, f_hash} + {16'h0000, left_q};
		fold1   = {17'h0_0000, rnd_sum[32]} + {2'b00, rnd_sum[31:16]}
		        + {2'b00, rnd_sum[15:0]};
		fold2   = {16'h0000, fold1[16]} + {1'b0, fold1[15:0]};
		if (cmd.round[0]) begin
			rnd_t = rnd_sum[15:0];
		end else if (fold2 >= 17'h0_ffff) begin
			rnd_t = 16'(fold2 - 17'h0_ffff);
		end else begin
			rnd_t = fold2[15:0];
		end
	end

	// pack halves back: hi * 0xffff + lo, wrapping at 32 bits
	always_comb begin
		if (right_q[15:0] == 16'hffff) begin
			pk_hi = {16'h0000, right_q[15:0]};
			pk_lo = {16'h0000, left_q[15:0]};
		end else begin
			pk_hi = {16'h0000, left_q[15:0]};
			pk_lo = {16'h0000, right_q[15:0]};
		end
		packed_val = (pk_hi << 16) - pk_hi + pk_lo;
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				value_q <= value_in;
				m_q     <= value_in[31:0] - MOD_B;
			end
			OP_SPLIT: begin
				left_q  <= split_left;
				right_q <= split_right;
			end
			OP_K1, OP_K2, OP_H1, OP_H2: begin
				acc_q <= prod[31:0];
			end
			OP_ROUND: begin
				left_q  <= right_q;
				right_q <= {1'b0, rnd_t};
			end
			OP_PACK: begin
				m_q <= packed_val;
			end
			OP_OUT: begin
				if (bypass) begin
					value_out_q <= value_q;
				end else begin
					value_out_q <= {value_q[63:32], m_q + MOD_B};
				end
			end
			default: begin
			end
		endcase
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/fcw_checker.sv
// port-level checker for the permutation unit, bound to the top level
module fcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] value_out
);

	// a held output item stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	// a held output item keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value_out))
		else $error("output item changed while stalled");

	// once an item is taken the unit is busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("unit took no notice of an accepted item");

	// a result only appears at the end of work on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the unit was idle");

endmodule

bind feistel_cycle_walk_permutation_unit fcw_checker u_fcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value_out (value_out)
);

// File: verif/tb_top.sv
// self-checking testbench for the feistel cycle-walk permutation unit
`timescale 1ns / 100ps

module tb_top;

	// permutation constants
	localparam logic [31:0]  SPLIT_MOD  = 32'h0000_ffff;
	localparam logic [31:0]  WRAP_MOD   = 32'h0001_0000;
	localparam logic [31:0]  WALK_FLOOR = 32'hffff_0000;
	localparam logic [127:0] ROUND_KEYS = {
		32'h4b38_7af7, 32'h85bc_ae01, 32'hee28_1300, 32'hb76d_5eed
	};

	// murmur3 x86_32 multipliers and key length
	localparam logic [31:0] HASH_K1  = 32'hcc9e_2d51;
	localparam logic [31:0] HASH_K2  = 32'h1b87_3593;
	localparam logic [31:0] HASH_M1  = 32'h85eb_ca6b;
	localparam logic [31:0] HASH_M2  = 32'hc2b2_ae35;
	localparam logic [31:0] HASH_LEN = 32'h0000_0002;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 60;
	localparam int unsigned PHASE_ITEMS = 130;
	localparam int unsigned PRINT_LIMIT = 20;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value_in;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] value_out;

	logic [63:0] expected_values[$];
	int unsigned error_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_target = 0;
	int unsigned hold_elapsed = 0;
	int unsigned quiet_cycles = 0;

	feistel_cycle_walk_permutation_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// two-byte murmur3 hash, low byte first
	function automatic logic [31:0] murmur_pair(input logic [15:0] key, input logic [31:0] seed);
		logic [31:0] k;
		logic [31:0] h;
		k = {16'h0000, key} * HASH_K1;
		k = {k[16:0], k[31:17]};
		k = k * HASH_K2;
		h = seed ^ k;
		h = h ^ HASH_LEN;
		h = h ^ (h >> 16);
		h = h * HASH_M1;
		h = h ^ (h >> 13);
		h = h * HASH_M2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// four feistel rounds, moduli alternating between 0xffff and 0x10000
	function automatic logic [31:0] feistel_mix(input logic [31:0] m);
		logic [63:0] lhs;
		logic [63:0] rhs;
		logic [63:0] sum;
		lhs = m % SPLIT_MOD;
		rhs = m / SPLIT_MOD;
		for (int r = 0; r < 4; r++) begin
			sum = murmur_pair(rhs[15:0], ROUND_KEYS[32*r +: 32]) + lhs;
			sum = (r % 2 == 1) ? sum % WRAP_MOD : sum % SPLIT_MOD;
			lhs = rhs;
			rhs = sum;
		end
		// a right half of 0xffff swaps the packing order
		if (rhs == SPLIT_MOD)
			return 32'(rhs * SPLIT_MOD + lhs);
		return 32'(lhs * SPLIT_MOD + rhs);
	endfunction

	// expected value_out for one value_in
	function automatic logic [63:0] predict_value(input logic [63:0] v);
		logic [31:0] c;
		if (v[31:0] < WRAP_MOD)
			return v;
		c = feistel_mix(v[31:0] - WRAP_MOD);
		// single cycle-walk step; the packed value tops out below the floor in practice
		if (c >= WALK_FLOOR)
			c = feistel_mix(c);
		return {v[63:32], c + WRAP_MOD};
	endfunction

	// walk the rounds backwards to get a low half whose final right half is 0xffff
	function automatic logic [31:0] top_right_low(input logic [15:0] pick);
		logic [63:0] r0;
		logic [63:0] r1;
		logic [63:0] r2;
		logic [63:0] r3;
		logic [63:0] l0;
		r3 = pick % SPLIT_MOD;
		r2 = (SPLIT_MOD + WRAP_MOD - murmur_pair(r3[15:0], ROUND_KEYS[96 +: 32]) % WRAP_MOD)
			% WRAP_MOD;
		r1 = (r3 + SPLIT_MOD - murmur_pair(r2[15:0], ROUND_KEYS[64 +: 32]) % SPLIT_MOD)
			% SPLIT_MOD;
		r0 = (r2 + WRAP_MOD - murmur_pair(r1[15:0], ROUND_KEYS[32 +: 32]) % WRAP_MOD)
			% WRAP_MOD;
		l0 = (r1 + SPLIT_MOD - murmur_pair(r0[15:0], ROUND_KEYS[0 +: 32]) % SPLIT_MOD)
			% SPLIT_MOD;
		return 32'(r0 * SPLIT_MOD + l0 + WRAP_MOD);
	endfunction

	// random value, biased toward the pass-through range, the range edges and swapped packing
	function automatic logic [63:0] random_value();
		logic [31:0] upper;
		logic [31:0] low;
		upper = $urandom;
		low = $urandom;
		case ($urandom_range(15))
			0, 1: low = low & 32'h0000_ffff;
			2: low = WRAP_MOD + (low & 32'h0000_00ff);
			3: low = 32'hffff_ff00 | (low & 32'h0000_00ff);
			4: low = top_right_low(low[15:0]);
			default: ;
		endcase
		return {upper, low};
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// offer one item, with random sender gaps ahead of it
	task automatic send_value(input logic [63:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			value_in <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= v;
		do @(posedge clk); while (in_stall);
		expected_values.push_back(predict_value(v));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_values.size() != 0);
	endtask

	task automatic run_random_items(input int unsigned count);
		repeat (count) send_value(random_value());
		wait_drained();
	endtask

	// low half below 0x10000 passes unchanged
	task automatic test_small_values();
		sender_idle_pct = 0;
		stall_pct = 0;
		send_value(64'h0000_0000_0000_0000);
		send_value(64'h0000_0000_0000_0001);
		send_value(64'h0000_0000_0000_ffff);
		send_value(64'hffff_ffff_0000_ffff);
		send_value(64'h8000_0000_0000_0000);
		send_value(64'h0000_0001_0000_0000);
		send_value(64'h5555_aaaa_0000_1234);
		wait_drained();
	endtask

	// ends of the permuted range and full-width patterns
	task automatic test_range_edges();
		send_value(64'h0000_0000_0001_0000);
		send_value(64'h0000_0000_0001_0001);
		send_value(64'h0000_0000_ffff_ffff);
		send_value(64'hffff_ffff_ffff_ffff);
		send_value(64'h0000_0000_ffff_0000);
		send_value(64'h0000_0000_fffe_ffff);
		send_value(64'h1234_5678_0001_ffff);
		send_value(64'haaaa_aaaa_5555_5555);
		send_value(64'h5555_5555_aaaa_aaaa);
		wait_drained();
	endtask

	// swapped packing when the final right half is 0xffff, values near the walk floor
	task automatic test_special_cases();
		send_value({32'h0000_0000, top_right_low(16'h0000)});
		send_value({32'hffff_ffff, top_right_low(16'hfffe)});
		send_value({$urandom, top_right_low(16'h8001)});
		send_value({$urandom, WALK_FLOOR + 32'($urandom_range(255))});
		send_value({$urandom, WALK_FLOOR - 32'h1});
		wait_drained();
	endtask

	task automatic test_streaming();
		sender_idle_pct = 0;
		stall_pct = 0;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_sender_gaps();
		sender_idle_pct = 46;
		stall_pct = 0;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_receiver_stalls();
		sender_idle_pct = 0;
		stall_pct = 46;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_both_idle();
		sender_idle_pct = 7;
		stall_pct = 7;
		run_random_items(PHASE_ITEMS);
	endtask

	// long receiver hold-off while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_target = hold_elapsed + HOLD_CYCLES;
		run_random_items(30);
	endtask

	// receiver: long hold-off when requested, else random stalls
	always @(posedge clk) begin
		if (hold_elapsed < hold_target) begin
			hold_elapsed <= hold_elapsed + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_values.size() == 0) begin
				report_mismatch($sformatf("unexpected item value_out=%h", value_out));
			end else begin
				want = expected_values.pop_front();
				if (value_out !== want)
					report_mismatch($sformatf("value_out=%h expected %h", value_out, want));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_in = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_values();
		test_range_edges();
		test_special_cases();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_output_backpressure();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
